/* sv/odometry_breadcrumb_path_recorder_macros.svh */
// assertion helpers for the breadcrumb path recorder
`ifndef ODOMETRY_BREADCRUMB_PATH_RECORDER_MACROS_SVH
`define ODOMETRY_BREADCRUMB_PATH_RECORDER_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define OBPR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("obpr check failed");

// next-cycle implication
`define OBPR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("obpr check failed");

`endif

/* sv/obpr_pkg.sv */
// ----------------------------------------------------------------------------
// obpr_pkg
// shared types, constants and the arctangent table of the path recorder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package obpr_pkg;

   localparam int STORE_DEPTH  = 1024;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = 5;
   localparam int CW           = 36;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [15:0] REC_DIST_RESET  = 16'd328;
   localparam logic [14:0] REC_ANG_RESET   = 15'd1043;
   localparam logic [15:0] CLR_DIST_RESET  = 16'd5243;
   localparam logic [14:0] CLR_ANG_RESET   = 15'd834;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_CLEAR  = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;
   localparam logic [1:0] CMD_SPARE  = 2'd3;

   localparam logic [1:0] MODE_RECORD = 2'd0;
   localparam logic [1:0] MODE_CLEAR  = 2'd1;
   localparam logic [1:0] MODE_IDLE   = 2'd2;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REC_DIST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REC_ANG  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLR_DIST = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLR_ANG  = 3'd4;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } req_type;

   typedef struct packed {
      logic             accepted;
      logic             pull_error;
      logic             store_full;
      logic [CNT_W-1:0] point_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [15:0]        yaw;
   } pose_type;

   typedef enum logic [2:0] {
      C_IDLE, C_PROD, C_PREP, C_ITER, C_DONE
   } cordic_state_type;

   typedef enum logic [2:0] {
      S_IDLE, S_YAW, S_SQ0, S_SQ1, S_SQ2, S_DECIDE
   } ctrl_state_type;

   function automatic logic [15:0] atan_lut(input logic [STEP_W-1:0] i);
      logic [15:0] v;
      case (i)
         5'd0:  v = 16'd8192;
         5'd1:  v = 16'd4836;
         5'd2:  v = 16'd2555;
         5'd3:  v = 16'd1297;
         5'd4:  v = 16'd651;
         5'd5:  v = 16'd326;
         5'd6:  v = 16'd163;
         5'd7:  v = 16'd81;
         5'd8:  v = 16'd41;
         5'd9:  v = 16'd20;
         5'd10: v = 16'd10;
         5'd11: v = 16'd5;
         5'd12: v = 16'd3;
         5'd13: v = 16'd1;
         5'd14: v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* sv/obpr_pose_ram.sv */
// ----------------------------------------------------------------------------
// obpr_pose_ram
// single-port-write, single-port-read pose store with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module obpr_pose_ram (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [obpr_pkg::ADDR_W-1:0] waddr,
   input  wire obpr_pkg::pose_type       wdata,
   input  wire logic                     re,
   input  wire logic [obpr_pkg::ADDR_W-1:0] raddr,
   output obpr_pkg::pose_type            rdata
);
   import obpr_pkg::*;

   pose_type mem [STORE_DEPTH];
   pose_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* sv/obpr_yaw_cordic.sv */
// ----------------------------------------------------------------------------
// obpr_yaw_cordic
// yaw from a quaternion by an iterative vectoring cordic, one step a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module obpr_yaw_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic signed [15:0] qx,
   input  wire logic signed [15:0] qy,
   input  wire logic signed [15:0] qz,
   input  wire logic signed [15:0] qw,
   output logic                    done,
   output logic [15:0]             yaw
);
   import obpr_pkg::*;

   cordic_state_type state_ff, state_in;
   logic signed [31:0] p_wz_ff, p_xy_ff, p_yy_ff, p_zz_ff;
   logic signed [CW-1:0] ax_ff, ay_ff, ax_in, ay_in;
   logic [15:0] ang_ff, ang_in;
   logic [STEP_W-1:0] step_ff;
   logic zero_ff;
   logic signed [CW-1:0] pre_x, pre_y, sx, sy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         C_IDLE: if (go) state_in = C_PROD;
         C_PROD: state_in = C_PREP;
         C_PREP: state_in = C_ITER;
         C_ITER: if (step_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = C_DONE;
         C_DONE: state_in = C_IDLE;
         default: state_in = C_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == C_DONE);
      yaw  = zero_ff ? 16'd0 : ang_ff;
   end

   // operands in Q2.28
   assign pre_y = CW'(2) * (CW'(p_wz_ff) + CW'(p_xy_ff));
   assign pre_x = (CW'(1) <<< 28) - CW'(2) * (CW'(p_yy_ff) + CW'(p_zz_ff));
   assign sx = ax_ff >>> step_ff;
   assign sy = ay_ff >>> step_ff;

   always_comb begin
      ax_in  = ax_ff;
      ay_in  = ay_ff;
      ang_in = ang_ff;
      if (state_ff == C_PREP) begin
         if (pre_x < 0) begin
            ax_in  = -pre_x;
            ay_in  = -pre_y;
            ang_in = 16'd32768;
         end else begin
            ax_in  = pre_x;
            ay_in  = pre_y;
            ang_in = 16'd0;
         end
      end else if (state_ff == C_ITER) begin
         if (ay_ff >= 0) begin
            ax_in  = ax_ff + sy;
            ay_in  = ay_ff - sx;
            ang_in = ang_ff + atan_lut(step_ff);
         end else begin
            ax_in  = ax_ff - sy;
            ay_in  = ay_ff + sx;
            ang_in = ang_ff - atan_lut(step_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == C_PROD) begin
         p_wz_ff <= qw * qz;
         p_xy_ff <= qx * qy;
         p_yy_ff <= qy * qy;
         p_zz_ff <= qz * qz;
      end
      if (state_ff == C_PREP) begin
         zero_ff <= (pre_x == 0) && (pre_y == 0);
         step_ff <= '0;
      end else if (state_ff == C_ITER) begin
         step_ff <= step_ff + 1'b1;
      end
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      ang_ff <= ang_in;
   end

endmodule
`default_nettype wire

/* sv/odometry_breadcrumb_path_recorder.sv */
// ----------------------------------------------------------------------------
// odometry_breadcrumb_path_recorder
// breadcrumb stack of robot poses, pushed and popped by odometry samples
// ----------------------------------------------------------------------------
// usage
//   raise start with a command and pose on req; the transaction is taken at
//   an edge where busy is low. busy stays high until the result is issued.
//   each transaction gives exactly one result on rsp, marked by rsp_strobe
//   for one cycle; the receiver has no way to stall it.
//   the result waits for the iterative yaw cordic, which takes one step a
//   cycle, and for the three coordinate differences that follow, squared in
//   turn on one multiplier in S_SQ0, S_SQ1 and S_SQ2. busy drops in the
//   strobe cycle, so a new transaction can follow then; none is taken while
//   one is in flight. registers are written through csr_we / csr_index /
//   csr_wdata only while idle, by the user; the block does not enforce it.
//   reset clears the stack depth and loads the register defaults; the pose
//   memory itself is never cleared, only entries below the depth are used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module odometry_breadcrumb_path_recorder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire obpr_pkg::req_type              req,
   output logic                                rsp_strobe,
   output obpr_pkg::rsp_type                   rsp,
   input  wire logic                           csr_we,
   input  wire logic [obpr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [obpr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import obpr_pkg::*;
   `include "odometry_breadcrumb_path_recorder_macros.svh"

   ctrl_state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_strobe_ff;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [1:0]  mode_ff;
   logic [15:0] rec_dist_ff, clr_dist_ff;
   logic [14:0] rec_ang_ff, clr_ang_ff;
   logic [15:0] yaw_ff;
   logic [63:0] sum_ff;
   logic        sat_ff;
   logic [31:0] thr_sq_ff;

   logic        accept, cordic_done;
   logic [15:0] cordic_yaw;
   pose_type    top_pose, wr_pose;
   logic        ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [CNT_W-1:0]  depth_m1;

   logic signed [31:0] cur_c, top_c;
   logic signed [32:0] diff;
   logic [32:0] mag;
   logic [61:0] sq;
   logic [15:0] dist_thr, yc;
   logic [14:0] ang_thr;
   logic dist_gt, pull_gt, yaw_gt, empty, full;

   assign accept   = start && !busy;
   assign depth_m1 = depth_ff - 1'b1;

   // the cordic takes its quaternion from the captured transaction
   obpr_yaw_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .go    (accept),
      .qx    (req_ff.quat_x),
      .qy    (req_ff.quat_y),
      .qz    (req_ff.quat_z),
      .qw    (req_ff.quat_w),
      .done  (cordic_done),
      .yaw   (cordic_yaw)
   );

   obpr_pose_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_pose),
      .re    (accept),
      .raddr (depth_m1[ADDR_W-1:0]),
      .rdata (top_pose)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RECORD;
         rec_dist_ff <= REC_DIST_RESET;
         rec_ang_ff  <= REC_ANG_RESET;
         clr_dist_ff <= CLR_DIST_RESET;
         clr_ang_ff  <= CLR_ANG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:     mode_ff     <= csr_wdata[1:0];
            CSR_REC_DIST: rec_dist_ff <= csr_wdata;
            CSR_REC_ANG:  rec_ang_ff  <= csr_wdata[14:0];
            CSR_CLR_DIST: clr_dist_ff <= csr_wdata;
            CSR_CLR_ANG:  clr_ang_ff  <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (accept) state_in = S_YAW;
         S_YAW:    if (cordic_done) state_in = S_SQ0;
         S_SQ0:    state_in = S_SQ1;
         S_SQ1:    state_in = S_SQ2;
         S_SQ2:    state_in = S_DECIDE;
         S_DECIDE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != S_IDLE);
   end

   // one coordinate difference squared per cycle
   always_comb begin
      case (state_ff)
         S_SQ0: begin cur_c = req_ff.pos_x; top_c = top_pose.x; end
         S_SQ1: begin cur_c = req_ff.pos_y; top_c = top_pose.y; end
         default: begin cur_c = req_ff.pos_z; top_c = top_pose.z; end
      endcase
      diff = {cur_c[31], cur_c} - {top_c[31], top_c};
      mag  = diff[32] ? 33'(-diff) : 33'(diff);
      sq   = 62'(mag[30:0]) * 62'(mag[30:0]);
   end

   assign dist_thr = (mode_ff == MODE_RECORD) ? rec_dist_ff : clr_dist_ff;
   assign ang_thr  = (mode_ff == MODE_RECORD) ? rec_ang_ff : clr_ang_ff;
   assign yc       = yaw_ff - top_pose.yaw;
   assign yaw_gt   = $signed(yc) > $signed({1'b0, ang_thr});
   assign dist_gt  = sat_ff || (sum_ff > {32'd0, thr_sq_ff});
   assign pull_gt  = sat_ff || (sum_ff > {30'd0, thr_sq_ff, 2'b00});
   assign empty    = (depth_ff == '0);
   assign full     = (depth_ff == CNT_W'(STORE_DEPTH));

   assign wr_pose.x   = req_ff.pos_x;
   assign wr_pose.y   = req_ff.pos_y;
   assign wr_pose.z   = req_ff.pos_z;
   assign wr_pose.yaw = yaw_ff;

   always_comb begin
      depth_in           = depth_ff;
      ram_we             = 1'b0;
      ram_waddr          = depth_ff[ADDR_W-1:0];
      rsp_in.accepted    = 1'b0;
      rsp_in.pull_error  = 1'b0;
      rsp_in.store_full  = 1'b0;
      if (state_ff == S_DECIDE) begin
         case (req_ff.command)
            CMD_SAMPLE: begin
               if (mode_ff == MODE_RECORD) begin
                  if (empty || dist_gt || yaw_gt) begin
                     if (!full) begin
                        ram_we          = 1'b1;
                        depth_in        = depth_ff + 1'b1;
                        rsp_in.accepted = 1'b1;
                     end else begin
                        rsp_in.store_full = 1'b1;
                     end
                  end
               end else if (mode_ff == MODE_CLEAR && !empty) begin
                  rsp_in.accepted   = dist_gt || yaw_gt;
                  rsp_in.pull_error = pull_gt;
                  if (dist_gt || yaw_gt) depth_in = depth_m1;
               end
            end
            CMD_CLEAR: depth_in = '0;
            CMD_START: begin
               ram_we          = 1'b1;
               ram_waddr       = '0;
               rsp_in.accepted = 1'b1;
               if (empty) depth_in = CNT_W'(1);
            end
            default: ;
         endcase
      end
      rsp_in.point_count = depth_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         depth_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         rsp_strobe_ff <= (state_ff == S_DECIDE);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req;
      if (state_ff == S_YAW && cordic_done) yaw_ff <= cordic_yaw;
      if (state_ff == S_SQ0) begin
         thr_sq_ff <= 32'(dist_thr) * 32'(dist_thr);
         sum_ff    <= 64'(sq);
         sat_ff    <= |mag[32:31];
      end else if (state_ff == S_SQ1 || state_ff == S_SQ2) begin
         sum_ff <= sum_ff + 64'(sq);
         sat_ff <= sat_ff || (|mag[32:31]);
      end
      if (state_ff == S_DECIDE) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   `OBPR_ASSERT_NOW(a_depth_range, 1'b1, depth_ff <= CNT_W'(STORE_DEPTH))
   `OBPR_ASSERT_NOW(a_count_matches, rsp_strobe, rsp.point_count == depth_ff)
   `OBPR_ASSERT_NEXT(a_busy_after_accept, accept, busy)
   `OBPR_ASSERT_NOW(a_full_not_taken, rsp_strobe && rsp.store_full, !rsp.accepted)

endmodule
`default_nettype wire
